### rtl/multigroup_collision_sampler_assert.svh
// ----------------------------------------------------------------------------
// multigroup collision sampler assertion macros
// clocked property checks that can be compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef MULTIGROUP_COLLISION_SAMPLER_ASSERT_SVH
`define MULTIGROUP_COLLISION_SAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MCS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mcs assertion failed");
`define MCS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mcs assertion failed");
`else
`define MCS_ASSERT(lbl, clk, rst, prop)
`define MCS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### rtl/mcs_pkg.sv
// ----------------------------------------------------------------------------
// mcs_pkg
// shared item types and constants of the collision sampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mcs_pkg;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_SCATTER = 2'd1;
  localparam logic [1:0] OP_SAMPLE  = 2'd2;
  localparam logic [1:0] OP_SPARE   = 2'd3;

  localparam int LN_LAT  = 27;
  localparam int DIV_LAT = 46;

  localparam logic [31:0] LN2_Q32  = 32'd2977044472;
  localparam logic [18:0] NU_RESET = 19'd163840;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  group;
    logic [31:0] total_xs;
    logic [31:0] fission_xs;
    logic [31:0] scatter_xs;
    logic [31:0] rand_distance;
    logic [31:0] rand_absorb;
    logic [31:0] rand_fission;
    logic [31:0] rand_yield;
  } in_t;

  typedef struct packed {
    logic [31:0] distance;
    logic        absorbed;
    logic        fissioned;
    logic [3:0]  neutron_count;
    logic        xs_error;
  } out_t;

endpackage

### rtl/mcs_neg_ln.sv
// ----------------------------------------------------------------------------
// mcs_neg_ln
// pipelined -ln(u) in q6.24: normalise, 24 squaring stages, ln2 scale
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mcs_neg_ln (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] u,
  output logic [29:0] ln
);

  logic [4:0]  lead;
  logic [31:0] xs [0:24];
  logic [23:0] fr [0:24];
  logic [4:0]  ps [0:24];
  logic [29:0] nl;
  logic [61:0] prod;

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (u[i]) lead = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= u << (5'd31 - lead);
      fr[0] <= '0;
      ps[0] <= lead;
    end
  end

  for (genvar k = 1; k <= 24; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(xs[k-1]) * 64'(xs[k-1]);
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        xs[k] <= t[32] ? t[32:1] : t[31:0];
        fr[k] <= {fr[k-1][22:0], t[32]};
        ps[k] <= ps[k-1];
      end
    end
  end

  assign prod = 62'(nl) * 62'(mcs_pkg::LN2_Q32);

  always_ff @(posedge clk) begin
    if (en) begin
      nl <= {6'd32 - {1'b0, ps[24]}, 24'd0} - 30'(fr[24]);
      ln <= prod[61:32];
    end
  end

endmodule

### rtl/mcs_div.sv
// ----------------------------------------------------------------------------
// mcs_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mcs_div (
  input  logic        clk,
  input  logic        en,
  input  logic [45:0] num,
  input  logic [31:0] den,
  output logic [45:0] quo
);

  logic [31:0] rem [0:45];
  logic [45:0] qs  [0:45];
  logic [45:0] ns  [0:45];
  logic [31:0] ds  [0:45];

  for (genvar k = 0; k < 46; k++) begin : g_st
    logic [31:0] rem_in;
    logic [45:0] q_in;
    logic [45:0] n_in;
    logic [31:0] d_in;
    logic [32:0] trial;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign n_in   = num;
      assign d_in   = den;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign q_in   = qs[k-1];
      assign n_in   = ns[k-1];
      assign d_in   = ds[k-1];
    end
    assign trial = {rem_in, n_in[45-k]};
    assign ge    = trial >= {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? 32'(trial - {1'b0, d_in}) : trial[31:0];
        qs[k]  <= {q_in[44:0], ge};
        ns[k]  <= n_in;
        ds[k]  <= d_in;
      end
    end
  end

  assign quo = qs[45];

endmodule

### rtl/multigroup_collision_sampler.sv
// throughput: one item per cycle while the result register is free or being taken; the whole pipeline advances together
// most of the latency comes from the 24-stage log squaring chain and the 46-stage divider
// load and scatter items update the tables at acceptance and give no result
// reset (rst, synchronous, high) clears valid bits and scatter sums and loads NU_RESET into nu_yield
// ----------------------------------------------------------------------------
// multigroup_collision_sampler
// per-group cross-section tables and a pipelined collision sampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multigroup_collision_sampler_assert.svh"
module multigroup_collision_sampler #(
  parameter int MAX_GROUPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mcs_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output mcs_pkg::out_t out_item,
  input  logic          cfg_we,
  input  logic [18:0]   cfg_data
);

  localparam int IW   = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SIDE = mcs_pkg::LN_LAT + mcs_pkg::DIV_LAT;

  typedef struct packed {
    logic        err;
    logic        ab;
    logic        fi;
    logic [3:0]  cnt;
    logic        sat;
    logic        oor;
    logic [31:0] total;
  } side_t;

  // whole pipe moves when the result register is free or being taken
  logic adv;
  logic accept;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  logic [18:0] nu_yield;

  // group tables
  logic [31:0] total_table   [0:MAX_GROUPS-1];
  logic [31:0] fission_table [0:MAX_GROUPS-1];
  logic [35:0] scatter_sum   [0:MAX_GROUPS-1];

  logic [IW-1:0] gidx;
  logic          g_oor;
  logic [36:0]   sum_add;
  assign gidx    = IW'(in_item.group);
  assign g_oor   = 32'(in_item.group) >= MAX_GROUPS;
  assign sum_add = {1'b0, scatter_sum[gidx]} + {5'd0, in_item.scatter_xs};

  always_ff @(posedge clk) begin
    if (rst) begin
      nu_yield <= mcs_pkg::NU_RESET;
    end else if (cfg_we) begin
      nu_yield <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !g_oor && in_item.opcode == mcs_pkg::OP_LOAD) begin
      total_table[gidx]   <= in_item.total_xs;
      fission_table[gidx] <= in_item.fission_xs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_GROUPS; i++) scatter_sum[i] <= '0;
    end else if (accept && !g_oor) begin
      if (in_item.opcode == mcs_pkg::OP_LOAD) begin
        scatter_sum[gidx] <= '0;
      end else if (in_item.opcode == mcs_pkg::OP_SCATTER) begin
        // saturate at all ones
        scatter_sum[gidx] <= sum_add[36] ? '1 : sum_add[35:0];
      end
    end
  end

  // stage a: table read
  logic        a_valid, a_oor;
  logic [31:0] a_total, a_fis, a_ra, a_rf, a_ry, a_u;
  logic [35:0] a_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= accept && in_item.opcode == mcs_pkg::OP_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_oor   <= g_oor;
      a_total <= total_table[gidx];
      a_fis   <= fission_table[gidx];
      a_sum   <= scatter_sum[gidx];
      a_ra    <= in_item.rand_absorb;
      a_rf    <= in_item.rand_fission;
      a_ry    <= in_item.rand_yield;
      a_u     <= in_item.rand_distance;
    end
  end

  // stage b: absorption and the two products
  logic [36:0] absorb;
  logic        b_valid, b_oor, b_err, b_sat;
  logic [31:0] b_total, b_fis, b_a, b_ry, b_u;
  logic [63:0] b_pa, b_pf;
  assign absorb = {5'd0, a_total} - {1'b0, a_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_oor   <= a_oor;
      b_err   <= absorb[36] || absorb == '0 || a_total == '0;
      b_sat   <= a_u == '0 || a_total == '0;
      b_total <= a_total;
      b_fis   <= a_fis;
      b_a     <= absorb[31:0];
      b_pa    <= 64'(a_ra) * 64'(a_total);
      b_pf    <= 64'(a_rf) * 64'(absorb[31:0]);
      b_ry    <= a_ry;
      b_u     <= a_u;
    end
  end

  // stage c: compares and the yield
  logic        ab_c, fi_c, up_c;
  logic        c_valid;
  side_t       c_side;
  logic [31:0] c_u;
  assign ab_c = !b_err && b_pa < {b_a, 32'd0};
  assign fi_c = ab_c && b_pf < {b_fis, 32'd0};
  assign up_c = b_ry < {nu_yield[15:0], 16'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side.err   <= b_err;
      c_side.ab    <= ab_c;
      c_side.fi    <= fi_c;
      c_side.cnt   <= fi_c ? {1'b0, nu_yield[18:16]} + 4'(up_c) : 4'd0;
      c_side.sat   <= b_sat;
      c_side.oor   <= b_oor;
      c_side.total <= b_total;
      c_u          <= b_u;
    end
  end

  // side line that runs alongside the log and the divider
  side_t           side   [0:SIDE-1];
  logic [SIDE-1:0] side_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_v <= '0;
    end else if (adv) begin
      side_v <= {side_v[SIDE-2:0], c_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= c_side;
      for (int k = 1; k < SIDE; k++) side[k] <= side[k-1];
    end
  end

  logic [29:0] ln;
  logic [45:0] quo;

  mcs_neg_ln u_ln (
    .clk (clk),
    .en  (adv),
    .u   (c_u),
    .ln  (ln)
  );

  mcs_div u_div (
    .clk (clk),
    .en  (adv),
    .num ({ln, 16'd0}),
    .den (side[mcs_pkg::LN_LAT-1].total),
    .quo (quo)
  );

  // result register
  side_t       last;
  logic [31:0] dist_val;
  assign last     = side[SIDE-1];
  assign dist_val = (last.sat || quo[45:32] != '0) ? '1 : quo[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= side_v[SIDE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (last.oor) begin
        out_item <= '{distance: '0, absorbed: 1'b0, fissioned: 1'b0,
                      neutron_count: '0, xs_error: 1'b1};
      end else begin
        out_item <= '{distance: dist_val, absorbed: last.ab, fissioned: last.fi,
                      neutron_count: last.cnt, xs_error: last.err};
      end
    end
  end

  `MCS_ASSERT(a_fis_needs_abs, clk, rst, out_valid && out_item.fissioned |-> out_item.absorbed)
  `MCS_ASSERT(a_no_abs_no_cnt, clk, rst, out_valid && !out_item.absorbed |-> out_item.neutron_count == 4'd0 && !out_item.fissioned)
  `MCS_ASSERT(a_err_no_abs, clk, rst, out_valid && out_item.xs_error |-> !out_item.absorbed)
  `MCS_ASSERT_NR(a_reset_empty, clk, rst |=> !out_valid)

endmodule
